FILE: src/path_common_prefix_length_macros.svh
// Assertion macros for path_common_prefix_length.sv, which checks its own logic.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef PATH_COMMON_PREFIX_LENGTH_MACROS_SVH
`define PATH_COMMON_PREFIX_LENGTH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCPL_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCPL_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

FILE: src/pcpl_pkg.sv
package pcpl_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LIMIT_BITS    = 16;
    localparam int LENGTH_BITS   = 16;
    localparam int CMP_BITS      = (POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS;

    localparam logic [POSITION_BITS-1:0] POS_MAX     = {POSITION_BITS{1'b1}};
    localparam logic [LIMIT_BITS-1:0]    LIMIT_RESET = LIMIT_BITS'(260);
    localparam logic [7:0]               BACKSLASH   = 8'h5C;
    localparam logic [7:0]               NUL         = 8'h00;

    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic [POSITION_BITS-1:0] last_separator;
        logic                     separator_seen;
        logic                     leading_separator;
    } t_state;

    typedef struct packed {
        logic                   emit;
        logic [LENGTH_BITS-1:0] prefix_length;
        logic [LENGTH_BITS-1:0] copy_length;
    } t_result;

    function automatic logic [7:0] fold_byte(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if ((v >= 8'h61 && v <= 8'h7A) || (v >= 8'hE0 && v <= 8'hF6) ||
            (v >= 8'hF8 && v <= 8'hFE)) begin
            r = v - 8'h20;
        end else if (v == 8'h88) begin
            r = 8'h5E;
        end else if (v == 8'h9A) begin
            r = 8'h8A;
        end else if (v == 8'h9C) begin
            r = 8'h8C;
        end else if (v == 8'h9E) begin
            r = 8'h8E;
        end else if (v == 8'hFF) begin
            r = 8'h9F;
        end
        return r;
    endfunction

endpackage

FILE: src/pcpl_if.sv
interface pcpl_in_if;
    import pcpl_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] char_a;
    logic [7:0] char_b;
    modport source (output valid, output char_a, output char_b, input ready);
    modport sink   (input valid, input char_a, input char_b, output ready);
endinterface

interface pcpl_out_if;
    import pcpl_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [LENGTH_BITS-1:0] prefix_length;
    logic [LENGTH_BITS-1:0] copy_length;
    modport source (output valid, output prefix_length, output copy_length, input ready);
    modport sink   (input valid, input prefix_length, input copy_length, output ready);
endinterface

interface pcpl_cfg_if;
    import pcpl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [LIMIT_BITS-1:0] copy_limit;
    modport source (output valid, output copy_limit, input ready);
    modport sink   (input valid, input copy_limit, output ready);
endinterface

FILE: src/pcpl_eval.sv
module pcpl_eval
    import pcpl_pkg::*;
(
    input  logic [7:0]            i_char_a,
    input  logic [7:0]            i_char_b,
    input  logic [LIMIT_BITS-1:0] i_copy_limit,
    input  t_state                i_state,
    output t_state                o_state,
    output t_result               o_result
);

    logic                     match;
    logic [POSITION_BITS-1:0] n_len;
    logic [POSITION_BITS-1:0] w_len;
    logic                     over_limit;

    always_comb begin
        match = (i_char_a != NUL) && (i_char_b != NUL) &&
                (fold_byte(i_char_a) == fold_byte(i_char_b));

        // Length reported when the comparison stops at this pair.
        if (i_char_a == NUL && i_char_b == NUL) begin
            n_len = i_state.position;
        end else if ((i_char_a == NUL && i_char_b == BACKSLASH) ||
                     (i_char_b == NUL && i_char_a == BACKSLASH)) begin
            n_len = (i_state.position == POSITION_BITS'(1) && i_state.leading_separator)
                    ? '0 : i_state.position;
        end else if (!i_state.separator_seen) begin
            n_len = '0;
        end else if (i_state.last_separator == POSITION_BITS'(1) &&
                     i_state.leading_separator) begin
            n_len = '0;
        end else begin
            n_len = i_state.last_separator;
        end
        if (n_len == POSITION_BITS'(2)) begin
            n_len = POSITION_BITS'(3);
        end

        over_limit = CMP_BITS'(n_len) >= CMP_BITS'(i_copy_limit);
        if (over_limit) begin
            w_len = '0;
        end else if (n_len > i_state.position && i_char_a == NUL) begin
            w_len = i_state.position;
        end else begin
            w_len = n_len;
        end

        o_result.emit = !match;
        o_result.prefix_length =
            (CMP_BITS'(n_len) > CMP_BITS'({LENGTH_BITS{1'b1}})) ? {LENGTH_BITS{1'b1}}
                                                               : LENGTH_BITS'(n_len);
        o_result.copy_length =
            (CMP_BITS'(w_len) > CMP_BITS'({LENGTH_BITS{1'b1}})) ? {LENGTH_BITS{1'b1}}
                                                               : LENGTH_BITS'(w_len);

        // Next state: advance on a match, clear after a result.
        o_state = '0;
        if (match) begin
            o_state = i_state;
            if (i_char_a == BACKSLASH) begin
                o_state.last_separator = i_state.position;
                o_state.separator_seen = 1'b1;
                if (i_state.position == '0) begin
                    o_state.leading_separator = 1'b1;
                end
            end
            if (i_state.position != POS_MAX) begin
                o_state.position = i_state.position + POSITION_BITS'(1);
            end
        end
    end

endmodule

FILE: src/path_common_prefix_length.sv
// A byte pair that ends the comparison passes the input register, then the result register.
// Throughput: one byte pair per cycle unless a finishing pair waits on a full result register;
// the fold, compare and counter update form one stage. A result waiting on the output does not
// block pairs that merely extend the match. Reset (i_rst_n low at a clock edge, synchronous)
// empties both stages, clears the match state and sets copy_limit to 260.
`include "path_common_prefix_length_macros.svh"

module path_common_prefix_length
    import pcpl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcpl_cfg_if.sink   i_cfg,
    pcpl_in_if.sink    i_in,
    pcpl_out_if.source o_out
);

    // Limit register writes must only happen while idle; the block does not enforce this.
    logic [LIMIT_BITS-1:0] r_copy_limit;

    // Input register stage: one byte pair held until the evaluation stage takes it.
    logic       r_in_valid;
    logic [7:0] r_char_a;
    logic [7:0] r_char_b;

    // Match state carried between pairs of the same comparison.
    t_state r_state;
    t_state n_state;

    // Result register stage.
    logic                   r_out_valid;
    logic [LENGTH_BITS-1:0] r_prefix_length;
    logic [LENGTH_BITS-1:0] r_copy_length;

    t_result w_result;
    logic    out_free;
    logic    s1_take;

    pcpl_eval u_eval (
        .i_char_a     (r_char_a),
        .i_char_b     (r_char_b),
        .i_copy_limit (r_copy_limit),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (w_result)
    );

    // The result register can take a new value when it is empty or being drained.
    // A pair that only extends the match needs no room in it, so it always moves on.
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_take  = r_in_valid && (!w_result.emit || out_free);

    assign i_in.ready  = !r_in_valid || s1_take;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.prefix_length = r_prefix_length;
    assign o_out.copy_length   = r_copy_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy_limit <= LIMIT_RESET;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_copy_limit <= i_cfg.copy_limit;
            end

            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (s1_take) begin
                r_in_valid <= 1'b0;
            end

            if (s1_take) begin
                r_state <= n_state;
            end

            if (s1_take && w_result.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Payload registers carry no reset.
        if (i_in.valid && i_in.ready) begin
            r_char_a <= i_in.char_a;
            r_char_b <= i_in.char_b;
        end
        if (s1_take && w_result.emit) begin
            r_prefix_length <= w_result.prefix_length;
            r_copy_length   <= w_result.copy_length;
        end
    end

    // The copy never runs past the reported length, and a length of two is never reported.
    `PCPL_ASSERT_SAME(a_copy_within_prefix, o_out.valid,
        o_out.copy_length <= o_out.prefix_length, "copy length exceeds prefix length")
    `PCPL_ASSERT_SAME(a_no_length_two, o_out.valid,
        o_out.prefix_length != LENGTH_BITS'(2), "prefix length of two was reported")
    // A finishing pair held back by a full result register must not disturb the match state.
    `PCPL_ASSERT_NEXT(a_stall_holds_state, r_in_valid && w_result.emit && !out_free,
        $stable(r_state), "match state changed while the finishing pair was stalled")
    // Once a result is taken the next comparison starts from a clear state.
    `PCPL_ASSERT_NEXT(a_clear_after_result, s1_take && w_result.emit,
        r_state == '0, "match state not cleared after a result")

endmodule

FILE: tb/sv/path_common_prefix_length_test.sv
`timescale 1ns / 1ps

module path_common_prefix_length_test;
    import pcpl_pkg::*;

    // A terminating byte pair passes the input register and then the result register of the block.
    localparam int RESULT_LATENCY = 2;

    // The ways in which a path pair can stop matching.
    typedef enum int {
        END_BOTH,
        END_A_UNC,
        END_B_UNC,
        END_A_SHORT,
        END_B_SHORT,
        END_DIFFER
    } t_end_kind;

    // The two lengths that one terminating transfer should produce.
    typedef struct {
        logic [LENGTH_BITS-1:0] prefix_length;
        logic [LENGTH_BITS-1:0] copy_length;
    } t_lengths;

    // Mirrors the match state and the copy limit of the block. Every input transfer is
    // fed to take_pair(); when a pair ends the comparison, the lengths it should give
    // are queued, and every output transfer is compared against the oldest of them.
    class t_prefix_board;
        logic [LIMIT_BITS-1:0]    copy_limit;
        logic [POSITION_BITS-1:0] position;
        logic [POSITION_BITS-1:0] last_separator;
        bit                       separator_seen;
        bit                       leading_separator;
        t_lengths                 awaited_lengths[$];
        int                       failures;

        function new();
            copy_limit = LIMIT_RESET;
            failures   = 0;
            clear_match();
        endfunction

        function void clear_match();
            position          = '0;
            last_separator    = '0;
            separator_seen    = 1'b0;
            leading_separator = 1'b0;
        endfunction

        function logic [7:0] fold_char(input logic [7:0] c);
            if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'hE0 && c <= 8'hF6) ||
                (c >= 8'hF8 && c <= 8'hFE)) begin
                return c - 8'h20;
            end
            case (c)
                8'h88: return 8'h5E;
                8'h9A: return 8'h8A;
                8'h9C: return 8'h8C;
                8'h9E: return 8'h8E;
                8'hFF: return 8'h9F;
                default: return c;
            endcase
        endfunction

        function void take_pair(input logic [7:0] ca, input logic [7:0] cb);
            int unsigned matched;
            int unsigned reported;
            int unsigned copied;
            t_lengths    want;
            matched = 32'(position);
            if (ca != NUL && cb != NUL && fold_char(ca) == fold_char(cb)) begin
                if (ca == BACKSLASH) begin
                    last_separator = position;
                    separator_seen = 1'b1;
                    if (position == 0) begin
                        leading_separator = 1'b1;
                    end
                end
                if (position != POS_MAX) begin
                    position = position + 1'b1;
                end
                return;
            end
            // Same path, then a backslash facing an end, then the component boundary.
            if (ca == NUL && cb == NUL) begin
                reported = matched;
            end else if ((ca == NUL && cb == BACKSLASH) || (cb == NUL && ca == BACKSLASH)) begin
                reported = (matched == 1 && leading_separator) ? 0 : matched;
            end else if (!separator_seen) begin
                reported = 0;
            end else if (last_separator == 1 && leading_separator) begin
                reported = 0;
            end else begin
                reported = 32'(last_separator);
            end
            if (reported == 2) begin
                reported = 3;
            end
            // Only the inflated length of three can exceed what the first path holds.
            if (reported >= copy_limit) begin
                copied = 0;
            end else begin
                copied = (reported > matched && ca == NUL) ? matched : reported;
            end
            want.prefix_length = (reported > 32'hFFFF) ? 16'hFFFF : LENGTH_BITS'(reported);
            want.copy_length   = (copied > 32'hFFFF) ? 16'hFFFF : LENGTH_BITS'(copied);
            awaited_lengths.push_back(want);
            clear_match();
        endfunction

        function void check_lengths(input logic [LENGTH_BITS-1:0] prefix,
                                    input logic [LENGTH_BITS-1:0] copy);
            t_lengths want;
            if (awaited_lengths.size() == 0) begin
                $error("unexpected result: prefix_length %0d, copy_length %0d", prefix, copy);
                failures++;
                return;
            end
            want = awaited_lengths.pop_front();
            if (prefix !== want.prefix_length) begin
                $error("prefix_length: expected %0d, actual %0d", want.prefix_length, prefix);
                failures++;
            end
            if (copy !== want.copy_length) begin
                $error("copy_length: expected %0d, actual %0d", want.copy_length, copy);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcpl_cfg_if cfg_ch ();
    pcpl_in_if  in_ch ();
    pcpl_out_if out_ch ();

    t_prefix_board board = new();

    // Odds of an idle burst before a transfer (sender) or of a stall burst (receiver);
    // zero switches that side's idling off.
    int gap_odds   = 0;
    int stall_odds = 0;
    int sent_pairs = 0;

    path_common_prefix_length dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // All transfers are observed here, on values settled before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                board.copy_limit = cfg_ch.copy_limit;
            end
            if (in_ch.valid && in_ch.ready) begin
                board.take_pair(in_ch.char_a, in_ch.char_b);
            end
            if (out_ch.valid && out_ch.ready) begin
                board.check_lengths(out_ch.prefix_length, out_ch.copy_length);
            end
        end
    end

    // The result side stalls in bursts while stall_odds allows it.
    initial begin : result_ready
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                stall = $urandom_range(1, 6);
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Called just after an edge; returns at the edge of the transfer, leaving valid high
    // so that a following pair can go out back to back.
    task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.char_a <= a;
        in_ch.char_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_pairs++;
    endtask

    // Holds the input back until every awaited result has arrived and the pipeline is empty.
    // The first edge lets the monitor record the last transfer before the queue is read.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.awaited_lengths.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    // The limit is only changed with the block idle and no path half way through.
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        settle();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.copy_limit <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Returns either the byte itself or another byte that folds to the same value.
    function automatic logic [7:0] twin_of(input logic [7:0] c);
        logic [7:0] t;
        t = c;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'hE0 && c <= 8'hF6) ||
            (c >= 8'hF8 && c <= 8'hFE)) begin
            t = c - 8'h20;
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hD6) ||
                     (c >= 8'hD8 && c <= 8'hDE)) begin
            t = c + 8'h20;
        end else begin
            case (c)
                8'h88: t = 8'h5E;
                8'h5E: t = 8'h88;
                8'h9A: t = 8'h8A;
                8'h8A: t = 8'h9A;
                8'h9C: t = 8'h8C;
                8'h8C: t = 8'h9C;
                8'h9E: t = 8'h8E;
                8'h8E: t = 8'h9E;
                8'hFF: t = 8'h9F;
                8'h9F: t = 8'hFF;
                default: t = c;
            endcase
        end
        return ($urandom_range(0, 1) != 0) ? t : c;
    endfunction

    // One well-formed path pair: a matching stretch rich in backslashes, mostly short,
    // now and then 20 to 300 bytes, closed by a pair that ends the comparison.
    task automatic send_random_path();
        int         common;
        logic [7:0] a;
        logic [7:0] b;
        common = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 12);
        for (int i = 0; i < common; i++) begin
            if ($urandom_range(0, 3) == 0 || (i == 0 && $urandom_range(0, 2) == 0)) begin
                a = BACKSLASH;
            end else begin
                a = 8'($urandom_range(1, 255));
            end
            send_pair(a, twin_of(a));
        end
        case (t_end_kind'($urandom_range(0, 5)))
            END_BOTH:    send_pair(NUL, NUL);
            END_A_UNC:   send_pair(NUL, BACKSLASH);
            END_B_UNC:   send_pair(BACKSLASH, NUL);
            END_A_SHORT: send_pair(NUL, 8'($urandom_range(1, 255)));
            END_B_SHORT: send_pair(8'($urandom_range(1, 255)), NUL);
            default: begin
                do begin
                    a = ($urandom_range(0, 3) == 0) ? BACKSLASH : 8'($urandom_range(1, 255));
                    b = 8'($urandom_range(1, 255));
                end while (board.fold_char(a) == board.fold_char(b));
                send_pair(a, b);
            end
        endcase
    endtask

    initial begin : stimulus
        logic [LIMIT_BITS-1:0] limit_value;
        int                    goal;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.char_a      <= NUL;
        in_ch.char_b      <= NUL;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.copy_limit <= LIMIT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed paths under the reset limit of 260.
        gap_odds   = 3;
        stall_odds = 3;
        // Two empty paths.
        send_pair(NUL, NUL);
        // A lone backslash on both sides, then the same path.
        send_pair(BACKSLASH, BACKSLASH);
        send_pair(NUL, NUL);
        // A lone leading backslash facing an end on either side reports nothing.
        send_pair(BACKSLASH, BACKSLASH);
        send_pair(NUL, BACKSLASH);
        send_pair(BACKSLASH, BACKSLASH);
        send_pair(BACKSLASH, NUL);
        // Same path of length two: reported as three, but only two bytes exist to copy.
        send_pair(8'h61, 8'h41);
        send_pair(8'hFF, 8'h9F);
        send_pair(NUL, NUL);
        // Boundary at index two with more of the first path left: three bytes copied.
        send_pair(8'h88, 8'h5E);
        send_pair(8'h9A, 8'h8A);
        send_pair(BACKSLASH, BACKSLASH);
        send_pair(8'h7A, 8'h5A);
        send_pair(8'h01, 8'h02);
        // Folded high bytes without any backslash; 0xF7 does not fold, so it differs.
        send_pair(8'h9C, 8'h8C);
        send_pair(8'h9E, 8'h8E);
        send_pair(8'hE0, 8'hC0);
        send_pair(8'hFE, 8'hDE);
        send_pair(8'hF7, 8'hD7);
        // Boundary at index one without a leading backslash.
        send_pair(8'hF8, 8'hD8);
        send_pair(BACKSLASH, BACKSLASH);
        send_pair(NUL, 8'h41);
        // Two leading backslashes then a difference: the lone-UNC rule reports nothing.
        send_pair(BACKSLASH, BACKSLASH);
        send_pair(BACKSLASH, BACKSLASH);
        send_pair(8'h42, 8'h43);

        // Random phases, each under its own limit and its own idling pattern. Every phase
        // closes with two empty ends, so the limit never changes in the middle of a path.
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: limit_value = 16'd1;
                1: limit_value = 16'hFFFF;
                2: limit_value = 16'd2;
                3: limit_value = 16'd3;
                4: limit_value = LIMIT_RESET;
                5: limit_value = LIMIT_BITS'($urandom_range(1, 8));
                6: limit_value = LIMIT_BITS'($urandom_range(4, 40));
                7: limit_value = LIMIT_BITS'($urandom_range(1, 300));
                default: limit_value = LIMIT_BITS'($urandom_range(1, 65535));
            endcase
            gap_odds   = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 4 : 2);
            stall_odds = ((phase + 1) % 3 == 0) ? 0 : (((phase + 1) % 3 == 1) ? 4 : 2);
            write_limit(limit_value);
            goal = sent_pairs + 160;
            while (sent_pairs < goal) begin
                // Mostly well-formed paths; the rest are raw pairs that may match by chance.
                if ($urandom_range(0, 6) == 0) begin
                    send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end else begin
                    send_random_path();
                end
                if ($urandom_range(0, 49) == 0) begin
                    settle();
                end
            end
            send_pair(NUL, NUL);
        end

        // Final part, free of idling, under the widest limit.
        gap_odds   = 0;
        stall_odds = 0;
        write_limit(16'hFFFF);
        for (int i = 0; i < 15; i++) begin
            send_random_path();
        end

        settle();
        if (board.failures == 0) begin
            $display("path_common_prefix_length regression: pass");
        end else begin
            $display("path_common_prefix_length regression: fail");
        end
        $finish;
    end

    // Several times the slowest correct run under the longest idle and stall bursts.
    initial begin : watchdog
        #1_000_000;
        $display("path_common_prefix_length regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/pcpl_pkg.sv
src/pcpl_if.sv
src/pcpl_eval.sv
src/path_common_prefix_length.sv
tb/sv/path_common_prefix_length_test.sv
